>>> rtl/core/pointwise_conv_16x16_mac_defines.svh
// ----------------------------------------------------------------------------
// pointwise_conv_16x16_mac_defines
// assertion macros of the pointwise convolution core
// ----------------------------------------------------------------------------
`ifndef POINTWISE_CONV_16X16_MAC_DEFINES_SVH
`define POINTWISE_CONV_16X16_MAC_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define PWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// types and constants of the pointwise convolution core
// ----------------------------------------------------------------------------
package pwc_pkg;

    localparam int CHANNELS  = 16;
    localparam int LANES     = 8;                  // dot-product engines
    localparam int LANE_AW   = 3;                  // bits that pick an engine
    localparam int W_W       = 8;                  // q1.7 weight
    localparam int F_W       = 16;                 // q6.10 feature / sum
    localparam int PROD_W    = W_W + F_W;
    localparam int FRAC_DROP = 7;                  // 17 fraction bits down to 10
    localparam int ACC_W     = F_W + FRAC_DROP;    // only the low bits reach the result
    localparam int QUADS     = CHANNELS / 4;
    localparam int ROW_W     = CHANNELS * W_W;     // one weight row
    localparam int PIX_W     = CHANNELS * F_W;     // all features or all sums
    localparam int HALF_W    = LANES * F_W;        // sums of one half pixel

    // input tdata layout, lowest bit up
    localparam int WROW_LSB    = 0;
    localparam int WROW_W      = 4;
    localparam int WEIGHTS_LSB = WROW_LSB + WROW_W;
    localparam int FEAT_LSB    = WEIGHTS_LSB + ROW_W;
    localparam int PART_LSB    = FEAT_LSB + PIX_W;
    localparam int IN_USED_W   = PART_LSB + PIX_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = PIX_W;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } opcode_t;

    // advance strobes of the engine stages
    typedef struct packed {
        logic en_mul;
        logic en_tree;
        logic en_acc;
    } pwc_stage_ctrl_t;

endpackage

>>> rtl/core/pwc_ram.sv
// ----------------------------------------------------------------------------
// pwc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word when both ports hit the same address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/pwc_engine.sv
// ----------------------------------------------------------------------------
// pwc_engine
// one 16-term dot-product engine: multiply, adder tree, partial-sum add
// ----------------------------------------------------------------------------
module pwc_engine
    import pwc_pkg::*;
(
    input  logic            clk,
    input  pwc_stage_ctrl_t ctrl,
    input  logic [ROW_W-1:0] weights,
    input  logic [PIX_W-1:0] features,
    input  logic [F_W-1:0]   partial,
    output logic [F_W-1:0]   sum
);

    logic signed [PROD_W-1:0] prod_full [CHANNELS];
    logic [ACC_W-1:0]         prod_reg  [CHANNELS];
    logic [ACC_W-1:0]         quad_next [QUADS];
    logic [ACC_W-1:0]         quad_reg  [QUADS];
    logic [ACC_W-1:0]         acc_next;
    logic [F_W-1:0]           part2_reg;
    logic [F_W-1:0]           part3_reg;
    logic [F_W-1:0]           sum_reg;

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            prod_full[i] = $signed(weights[W_W*i +: W_W]) * $signed(features[F_W*i +: F_W]);
        end
    end

    // sums wrap modulo 2^ACC_W, which leaves the kept result bits exact
    always_comb
    begin
        for (int q = 0; q < QUADS; q++)
        begin
            quad_next[q] = prod_reg[4*q] + prod_reg[4*q+1] + prod_reg[4*q+2]
                         + prod_reg[4*q+3];
        end
    end

    always_comb
    begin
        acc_next = {part3_reg, {FRAC_DROP{1'b0}}};
        for (int q = 0; q < QUADS; q++)
        begin
            acc_next = acc_next + quad_reg[q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_mul)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                prod_reg[i] <= prod_full[i][ACC_W-1:0];
            end
            part2_reg <= partial;
        end
        if (ctrl.en_tree)
        begin
            for (int q = 0; q < QUADS; q++)
            begin
                quad_reg[q] <= quad_next[q];
            end
            part3_reg <= part2_reg;
        end
        if (ctrl.en_acc)
        begin
            // floor to ten fraction bits
            sum_reg <= acc_next[ACC_W-1:FRAC_DROP];
        end
    end

    assign sum = sum_reg;

endmodule

>>> rtl/core/pointwise_conv_16x16_mac.sv
// ----------------------------------------------------------------------------
// pointwise_conv_16x16_mac
// 1x1 convolution, 16 input by 16 output channels, q1.7 weights, q6.10 data
// ----------------------------------------------------------------------------
// A weight-load transaction (tuser low) writes one row of 16 weights; it gives
// no result. In a pixel transaction (tuser high) eight dot-product engines each
// work out two output channels, the low eight first and the high eight after,
// and each engine reads its own two-row weight ram once for each half. A new
// transaction is taken as the high half of the last pixel is issued. The result
// passes the issue, ram read, multiply, adder tree and partial-sum stages into
// the output register, where it waits while further transactions are taken. A
// weight row that was never loaded gives undefined sums for its channel. Sums
// wrap to 16 bits.
// ----------------------------------------------------------------------------
module pointwise_conv_16x16_mac
    import pwc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // weight_row[3:0], weights_low, weights_high, feature_pack0..3,
    // partial_pack0..3, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // sum_pack0, sum_pack1, sum_pack2, sum_pack3
    output logic [OUT_TDATA_W-1:0] m_tdata
);

`include "pointwise_conv_16x16_mac_defines.svh"

    logic [WROW_W-1:0] in_row;
    logic [ROW_W-1:0]  in_weights;
    logic [PIX_W-1:0]  in_feat;
    logic [PIX_W-1:0]  in_part;
    opcode_t           in_op;
    logic              in_fire;
    logic              load_fire;
    logic              pixel_fire;

    // issue stage
    logic              s0_valid_reg, s0_valid_next;
    logic              s0_phase_reg, s0_phase_next;
    logic [PIX_W-1:0]  s0_feat_reg;
    logic [PIX_W-1:0]  s0_part_reg;
    logic              s0_adv;

    // ram read stage
    logic              s1_valid_reg;
    logic              s1_phase_reg;
    logic [PIX_W-1:0]  s1_feat_reg;
    logic [HALF_W-1:0] s1_part_reg;

    logic              s2_valid_reg, s2_phase_reg;
    logic              s3_valid_reg, s3_phase_reg;
    logic              s4_valid_reg, s4_phase_reg;
    logic              s1_ready, s2_ready, s3_ready, s4_ready;
    logic              s4_fire;
    pwc_stage_ctrl_t   ctrl;

    logic [ROW_W-1:0]  lane_weights [LANES];
    logic [HALF_W-1:0] lane_sums;

    logic              lo_valid_reg, lo_valid_next;
    logic [HALF_W-1:0] lo_sums_reg;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_data_reg;
    logic              out_ready_int;

    assign in_row     = s_tdata[WROW_LSB +: WROW_W];
    assign in_weights = s_tdata[WEIGHTS_LSB +: ROW_W];
    assign in_feat    = s_tdata[FEAT_LSB +: PIX_W];
    assign in_part    = s_tdata[PART_LSB +: PIX_W];
    assign in_op      = opcode_t'(s_tuser);

    // a pixel holds the issue stage for both halves
    assign s_tready   = !s0_valid_reg || (s0_phase_reg && s1_ready);
    assign in_fire    = s_tvalid && s_tready;
    assign load_fire  = in_fire && (in_op == OP_LOAD);
    assign pixel_fire = in_fire && (in_op == OP_PIXEL);

    assign out_ready_int = !out_valid_reg || m_tready;
    assign s4_ready = !s4_valid_reg || !s4_phase_reg || out_ready_int;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_adv   = s0_valid_reg && s1_ready;
    assign s4_fire  = s4_valid_reg && s4_ready;

    assign ctrl.en_mul  = s1_valid_reg && s2_ready;
    assign ctrl.en_tree = s2_valid_reg && s3_ready;
    assign ctrl.en_acc  = s3_valid_reg && s4_ready;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        s0_phase_next = s0_phase_reg;
        if (s0_adv)
        begin
            s0_phase_next = 1'b1;
            s0_valid_next = !s0_phase_reg;
        end
        if (pixel_fire)
        begin
            s0_valid_next = 1'b1;
            s0_phase_next = 1'b0;
        end
    end

    // engine e keeps row e at address 0 and row e+8 at address 1
    for (genvar e = 0; e < LANES; e++)
    begin : g_lane
        pwc_ram #(
            .WIDTH (ROW_W),
            .DEPTH (2)
        ) u_ram (
            .clk     (clk),
            .wr_en   (load_fire && (in_row[LANE_AW-1:0] == LANE_AW'(e))),
            .wr_addr (in_row[LANE_AW]),
            .wr_data (in_weights),
            .rd_en   (s0_adv),
            .rd_addr (s0_phase_reg),
            .rd_data (lane_weights[e])
        );

        pwc_engine u_engine (
            .clk      (clk),
            .ctrl     (ctrl),
            .weights  (lane_weights[e]),
            .features (s1_feat_reg),
            .partial  (s1_part_reg[F_W*e +: F_W]),
            .sum      (lane_sums[F_W*e +: F_W])
        );
    end

    always_comb
    begin
        lo_valid_next  = lo_valid_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s4_fire)
        begin
            lo_valid_next = !s4_phase_reg;
            if (s4_phase_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s0_phase_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_phase_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s3_phase_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s4_phase_reg  <= 1'b0;
            lo_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s0_phase_reg <= s0_phase_next;
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
                s1_phase_reg <= s0_phase_reg;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
                s2_phase_reg <= s1_phase_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
                s3_phase_reg <= s2_phase_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
                s4_phase_reg <= s3_phase_reg;
            end
            lo_valid_reg  <= lo_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_fire)
        begin
            s0_feat_reg <= in_feat;
            s0_part_reg <= in_part;
        end
        if (s0_adv)
        begin
            s1_feat_reg <= s0_feat_reg;
            s1_part_reg <= s0_phase_reg ? s0_part_reg[HALF_W +: HALF_W]
                                        : s0_part_reg[0 +: HALF_W];
        end
        if (s4_fire && !s4_phase_reg)
        begin
            lo_sums_reg <= lane_sums;
        end
        if (s4_fire && s4_phase_reg)
        begin
            out_data_reg <= {lane_sums, lo_sums_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `PWC_ASSERT_NOW(a_low_half_slot_free, clk, rst_n, s4_fire && !s4_phase_reg,
        !lo_valid_reg, "low half overwrites a pending low half")
    `PWC_ASSERT_NOW(a_high_half_paired, clk, rst_n, s4_fire && s4_phase_reg,
        lo_valid_reg, "high half arrives without its low half")
    `PWC_ASSERT_NOW(a_no_take_mid_pixel, clk, rst_n, s0_valid_reg && !s0_phase_reg,
        !s_tready, "transaction taken before the low half was issued")
    `PWC_ASSERT_NEXT(a_pixel_enters_issue, clk, rst_n, pixel_fire,
        s0_valid_reg && !s0_phase_reg, "accepted pixel missing from issue stage")

endmodule

>>> tb/pointwise_conv_16x16_mac_tb.sv
// ----------------------------------------------------------------------------
// pointwise_conv_16x16_mac_tb
// self-checking bench for the 16x16 pointwise convolution core: weight-row
// loads and pixels are streamed through, mixed. Every sum pack is compared
// with a local fixed-point model of the dot products or with sums given by
// the directed item, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module pointwise_conv_16x16_mac_tb
    import pwc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        opcode_t             op;
        logic [WROW_W-1:0]   row;
        logic [ROW_W-1:0]    weights;    // weights_low in the low half
        logic [PIX_W-1:0]    features;   // feature_pack0 lowest
        logic [PIX_W-1:0]    partials;   // partial_pack0 lowest
    } conv_item_t;

    typedef struct {
        conv_item_t          item;
        bit                  typed;
        logic [PIX_W-1:0]    sums;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // local copy of the weight store, indexed [output channel][input channel]
    logic [W_W-1:0]   weight_rows [CHANNELS][CHANNELS];
    logic [PIX_W-1:0] pending_sums [$];
    directed_row_t    directed_rows [$];

    int  n_errors  = 0;
    int  n_loads   = 0;
    int  n_pixels  = 0;
    int  n_checked = 0;
    int  cycles    = 0;
    bit  steady    = 1'b0;
    bit  hold_request = 1'b0;

    pointwise_conv_16x16_mac uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // new sums of all output channels, floored to q6.10 and wrapped
    function automatic logic [PIX_W-1:0] predict_sums(logic [PIX_W-1:0] features,
                                                      logic [PIX_W-1:0] partials);
        logic [PIX_W-1:0] sums;
        longint           acc;
        for (int co = 0; co < CHANNELS; co++)
        begin
            acc = longint'($signed(partials[F_W*co +: F_W])) * 128;
            for (int ci = 0; ci < CHANNELS; ci++)
                acc += longint'($signed(weight_rows[co][ci]))
                     * longint'($signed(features[F_W*ci +: F_W]));
            sums[F_W*co +: F_W] = F_W'(acc >>> FRAC_DROP);
        end
        return sums;
    endfunction

    function automatic logic [W_W-1:0] pick_weight();
        logic [W_W-1:0] corners [5] = '{8'h7f, 8'h80, 8'h00, 8'hff, 8'h01};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 4)];
        return W_W'($urandom);
    endfunction

    function automatic logic [F_W-1:0] pick_q610();
        logic [F_W-1:0] corners [5] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 4)];
        return F_W'($urandom);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic conv_item_t random_item();
        conv_item_t it;
        logic [F_W-1:0] flat;
        it.op  = ($urandom_range(0, 99) < 15) ? OP_LOAD : OP_PIXEL;
        it.row = WROW_W'($urandom_range(0, CHANNELS-1));
        for (int j = 0; j < CHANNELS; j++)
            it.weights[W_W*j +: W_W] = pick_weight();
        // now and then some features share one value, to push the wrap
        flat = pick_q610();
        for (int k = 0; k < CHANNELS; k++)
        begin
            it.features[F_W*k +: F_W] = ($urandom_range(0, 9) == 0) ? flat : pick_q610();
            it.partials[F_W*k +: F_W] = pick_q610();
        end
        return it;
    endfunction

    function automatic directed_row_t make_row(opcode_t op, logic [WROW_W-1:0] row,
                                               logic [ROW_W-1:0] weights,
                                               logic [PIX_W-1:0] features,
                                               logic [PIX_W-1:0] partials,
                                               bit typed, logic [PIX_W-1:0] sums);
        directed_row_t d;
        d.item = '{op, row, weights, features, partials};
        d.typed = typed;
        d.sums  = sums;
        return d;
    endfunction

    // offer one transaction, wait for it to be taken, then idle a while
    task automatic send_item(conv_item_t it, bit typed, logic [PIX_W-1:0] typed_sums);
        logic [IN_TDATA_W-1:0] d;
        int gap;
        d = '0;
        d[WROW_LSB    +: WROW_W] = it.row;
        d[WEIGHTS_LSB +: ROW_W]  = it.weights;
        d[FEAT_LSB    +: PIX_W]  = it.features;
        d[PART_LSB    +: PIX_W]  = it.partials;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= it.op;
        do
            @(posedge clk);
        while (!s_tready);
        if (it.op == OP_LOAD)
        begin
            for (int ci = 0; ci < CHANNELS; ci++)
                weight_rows[it.row][ci] = it.weights[W_W*ci +: W_W];
            n_loads++;
        end
        else
        begin
            pending_sums.push_back(typed ? typed_sums : predict_sums(it.features, it.partials));
            n_pixels++;
        end
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_sums(logic [OUT_TDATA_W-1:0] got);
        logic [PIX_W-1:0] want;
        if (pending_sums.size() == 0)
        begin
            $error("unexpected result transaction: %h", got);
            n_errors++;
            return;
        end
        want = pending_sums.pop_front();
        n_checked++;
        for (int p = 0; p < QUADS; p++)
            if (got[64*p +: 64] !== want[64*p +: 64])
            begin
                $error("sum_pack%0d: expected %h, actual %h", p, want[64*p +: 64],
                       got[64*p +: 64]);
                n_errors++;
            end
    endtask

    // result side: random ready with short and long stalls, plus one long hold
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_sums(m_tdata);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (steady || $urandom_range(0, 99) < 70)
                m_tready <= 1'b1;
            else
            begin
                stall_left = idle_len();
                m_tready <= 1'b0;
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("pointwise_conv_16x16_mac_tb failed");
        $finish;
    end

    initial
    begin
        // every row starts at zero weights, so the first pixels give back the partials
        for (int r = 0; r < CHANNELS; r++)
            directed_rows.push_back(make_row(OP_LOAD, WROW_W'(r), '0, {16{16'ha5a5}},
                                             {16{16'h5a5a}}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_PIXEL, 4'hf, '1, {16{16'h7fff}},
                                         {4{16'h7fff, 16'h8000, 16'h0000, 16'hffff}},
                                         1'b1, {4{16'h7fff, 16'h8000, 16'h0000, 16'hffff}}));
        directed_rows.push_back(make_row(OP_PIXEL, 4'h0, '0, {16{16'h8000}},
                                         {16{16'h0001}}, 1'b1, {16{16'h0001}}));
        directed_rows.push_back(make_row(OP_LOAD, 4'h0, {16{8'h7f}}, '0, '0, 1'b0, '0));
        directed_rows.push_back(make_row(OP_LOAD, 4'h1, {16{8'h80}}, '1, '1, 1'b0, '0));
        directed_rows.push_back(make_row(OP_LOAD, 4'hf, {8{8'hff, 8'h01}}, '0, '0, 1'b0, '0));
        // largest products, both signs, with partials at zero or at the edges to force the wrap
        directed_rows.push_back(make_row(OP_PIXEL, 4'h0, '0, {16{16'h7fff}}, '0, 1'b0, '0));
        directed_rows.push_back(make_row(OP_PIXEL, 4'h0, '0, {16{16'h8000}},
                                         {16{16'h8000}}, 1'b0, '0));
        directed_rows.push_back(make_row(OP_PIXEL, 4'h0, '0, {8{16'h7fff, 16'h8000}},
                                         {16{16'h7fff}}, 1'b0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].sums);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 150 && n < 250);
            if (n == 350)
                hold_request = 1'b1;
            if (n == 450 && pending_sums.size() != 0)
            begin
                // let the pipeline run dry before carrying on
                s_tvalid <= 1'b0;
                while (pending_sums.size() != 0)
                    @(posedge clk);
            end
            send_item(random_item(), 1'b0, '0);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d weight-row loads and %0d pixels sent, %0d sum transactions checked",
                 n_loads, n_pixels, n_checked);
        $display("%0d mismatches, %0d cycles", n_errors, cycles);
        if (n_errors == 0)
            $display("pointwise_conv_16x16_mac_tb passed");
        else
            $display("pointwise_conv_16x16_mac_tb failed");
        $finish;
    end

endmodule
